### rtl/circle_pixel_rasterizer_assert.svh
// Assertion macros shared by the circle rasterizer RTL.
`ifndef CIRCLE_PIXEL_RASTERIZER_ASSERT_SVH
`define CIRCLE_PIXEL_RASTERIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circle rasterizer: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CPR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circle rasterizer: next-cycle check failed");

`endif

### rtl/cpr_pkg.sv
// Types and constants shared by the circle rasterizer modules.
package cpr_pkg;

  localparam int CC_W     = 8;
  localparam int CR_W     = 9;
  localparam int RAD_W    = 8;
  localparam int NIB_W    = 4;
  localparam int COLOUR_W = 16;
  localparam int IDX_W    = 17;
  localparam int STEP_W   = 8;
  localparam int DEC_W    = 12;
  localparam int OCT_W    = 3;
  // covers any screen dimension up to 1024
  localparam int COORD_W  = 10;

  localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

  localparam int DEC_INIT    = 3;
  localparam int DEC_INC_NEG = 6;
  localparam int DEC_INC_POS = 10;

  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_ACCEPT = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_PIXEL  = 2'd2,
    STAT_IDLE   = 2'd3
  } status_t;

  // one classified transaction, front to back
  typedef struct packed {
    status_t              status;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic [COLOUR_W-1:0]  colour;
    logic                 last;
  } cmd_t;

endpackage

### rtl/cpr_fifo.sv
// Small register queue between the front and back of the rasterizer.
`include "circle_pixel_rasterizer_assert.svh"

module cpr_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  cpr_pkg::cmd_t wr_data,
  input  logic          rd,
  output cpr_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);
  import cpr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `CPR_ASSERT_IMP(a_no_overflow, clk, rst, wr, !full)
  `CPR_ASSERT_IMP(a_no_underflow, clk, rst, rd, !empty)
  `CPR_ASSERT_NXT(a_count_up, clk, rst, wr && !rd, count == $past(count) + 1'b1)

endmodule

### rtl/cpr_front.sv
// Front end: takes transactions, checks bounds, steps the midpoint circle.
`include "circle_pixel_rasterizer_assert.svh"

module cpr_front #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        func,
  input  logic [cpr_pkg::CC_W-1:0]    centre_col,
  input  logic [cpr_pkg::CR_W-1:0]    centre_row,
  input  logic [cpr_pkg::RAD_W-1:0]   radius,
  input  logic [cpr_pkg::NIB_W-1:0]   alpha_nibble,
  input  logic [cpr_pkg::NIB_W-1:0]   red_nibble,
  input  logic [cpr_pkg::NIB_W-1:0]   green_nibble,
  input  logic [cpr_pkg::NIB_W-1:0]   blue_nibble,
  output logic                        cmd_valid,
  output cpr_pkg::cmd_t               cmd
);
  import cpr_pkg::*;

  // extra-bit width for unsigned bound checks and signed pixel coordinates
  localparam int CHK_W = COORD_W + 1;
  localparam int XY_W  = STEP_W + 1;

  logic                    active;
  logic [CC_W-1:0]         centre_col_reg;
  logic [CR_W-1:0]         centre_row_reg;
  logic [STEP_W-1:0]       step_x;
  logic [STEP_W-1:0]       step_y;
  logic signed [DEC_W-1:0] decision;
  logic [OCT_W-1:0]        octant;
  logic [COLOUR_W-1:0]     colour_reg;

  logic                    reject;
  logic [COLOUR_W-1:0]     colour_in;
  logic [CHK_W-1:0]        cc_u, cr_u, r_u;
  logic signed [CHK_W-1:0] cc_s, cr_s, x_s, y_s, col_s, row_s;
  logic signed [DEC_W-1:0] x_d, y_d, decision_next;
  logic [STEP_W-1:0]       step_y_next;
  logic signed [XY_W-1:0]  x9_next, y9_next;
  logic                    y_down;
  logic                    circle_done;

  always_comb begin
    cc_u      = CHK_W'(centre_col);
    cr_u      = CHK_W'(centre_row);
    r_u       = CHK_W'(radius);
    reject    = (cc_u < r_u) || (cc_u + r_u > CHK_W'(SCREEN_WIDTH - 1)) ||
                (cr_u < r_u) || (cr_u + r_u > CHK_W'(SCREEN_HEIGHT - 1));
    colour_in = {alpha_nibble, red_nibble, green_nibble, blue_nibble};

    cc_s = $signed(CHK_W'(centre_col_reg));
    cr_s = $signed(CHK_W'(centre_row_reg));
    x_s  = $signed(CHK_W'(step_x));
    y_s  = $signed(CHK_W'(step_y));
    unique case (octant)
      3'd0:    begin col_s = cc_s + x_s; row_s = cr_s + y_s; end
      3'd1:    begin col_s = cc_s - x_s; row_s = cr_s + y_s; end
      3'd2:    begin col_s = cc_s + x_s; row_s = cr_s - y_s; end
      3'd3:    begin col_s = cc_s - x_s; row_s = cr_s - y_s; end
      3'd4:    begin col_s = cc_s + y_s; row_s = cr_s + x_s; end
      3'd5:    begin col_s = cc_s - y_s; row_s = cr_s + x_s; end
      3'd6:    begin col_s = cc_s + y_s; row_s = cr_s - x_s; end
      default: begin col_s = cc_s - y_s; row_s = cr_s - x_s; end
    endcase

    // decision update at the end of an iteration
    x_d    = $signed(DEC_W'(step_x));
    y_d    = $signed(DEC_W'(step_y));
    y_down = !decision[DEC_W-1];
    if (y_down) begin
      decision_next = decision + ((x_d - y_d) <<< 2) + DEC_W'(DEC_INC_POS);
      step_y_next   = step_y - 1'b1;
    end else begin
      decision_next = decision + (x_d <<< 2) + DEC_W'(DEC_INC_NEG);
      step_y_next   = step_y;
    end
    // y may pass below zero on a zero radius: compare with a sign bit
    x9_next     = $signed(XY_W'(step_x)) + XY_W'(1);
    y9_next     = $signed(XY_W'(step_y)) - XY_W'(y_down);
    circle_done = (x9_next > y9_next);

    cmd_valid = in_valid;
    cmd       = '0;
    if (func == FUNC_START) begin
      if (reject) begin
        cmd.status = STAT_REJECT;
      end else begin
        cmd.status = STAT_ACCEPT;
        cmd.colour = colour_in;
      end
    end else if (!active) begin
      cmd.status = STAT_IDLE;
    end else begin
      cmd.status = STAT_PIXEL;
      cmd.col    = col_s[CHK_W-1] ? '0 : col_s[COORD_W-1:0];
      cmd.row    = row_s[CHK_W-1] ? '0 : row_s[COORD_W-1:0];
      cmd.colour = colour_reg;
      cmd.last   = (octant == OCT_LAST) && circle_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      octant <= '0;
    end else if (in_valid) begin
      if (func == FUNC_START) begin
        active <= !reject;
        octant <= '0;
      end else if (active) begin
        if (octant == OCT_LAST) begin
          octant <= '0;
          if (circle_done) begin
            active <= 1'b0;
          end
        end else begin
          octant <= octant + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (func == FUNC_START) begin
        if (!reject) begin
          centre_col_reg <= centre_col;
          centre_row_reg <= centre_row;
          colour_reg     <= colour_in;
          step_x         <= '0;
          step_y         <= radius;
          decision       <= DEC_W'(DEC_INIT) - (DEC_W'(radius) <<< 1);
        end
      end else if (active && octant == OCT_LAST) begin
        decision <= decision_next;
        step_y   <= step_y_next;
        step_x   <= step_x + 1'b1;
      end
    end
  end

  `CPR_ASSERT_NXT(a_last_ends, clk, rst, cmd_valid && cmd.last, !active)
  `CPR_ASSERT_NXT(a_reject_idle, clk, rst, cmd_valid && cmd.status == STAT_REJECT, !active)
  `CPR_ASSERT_IMP(a_x_le_y, clk, rst, active, step_x <= step_y)

endmodule

### rtl/cpr_back.sv
// Back end: turns coordinates into a framebuffer index and holds the result.
module cpr_back #(
  parameter int SCREEN_WIDTH = 240
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  cpr_pkg::cmd_t                 cmd,
  output logic                          cmd_take,
  input  logic                          pop,
  output logic                          empty,
  output logic [1:0]                    status,
  output logic [cpr_pkg::IDX_W-1:0]     pixel_index,
  output logic [cpr_pkg::COLOUR_W-1:0]  pixel_colour,
  output logic                          last_pixel
);
  import cpr_pkg::*;

  localparam int PROD_W = COORD_W + $clog2(SCREEN_WIDTH + 1) + 1;
  localparam int MUL_W  = (PROD_W > IDX_W) ? PROD_W : IDX_W;

  logic             out_valid;
  logic [MUL_W-1:0] index_full;

  assign index_full = MUL_W'(cmd.row) * MUL_W'(SCREEN_WIDTH) + MUL_W'(cmd.col);
  assign cmd_take   = cmd_valid && (!out_valid || pop);
  assign empty      = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      status       <= cmd.status;
      pixel_index  <= index_full[IDX_W-1:0];
      pixel_colour <= cmd.colour;
      last_pixel   <= cmd.last;
    end
  end

endmodule

### rtl/circle_pixel_rasterizer.sv
// Top level of the midpoint circle pixel rasterizer.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  input    | push / full        | func, centre_col, centre_row, radius, nibbles
//  result   | pop / empty        | status, pixel_index, pixel_colour, last_pixel
//
// One transaction in, one result out; a new transaction is taken every cycle
// while the queue is not full. The front stage steps the circle state at
// accept and writes a queue; the back stage multiplies row by screen width
// into the result register. The front-to-back queue holds two entries.
// Reset (rst, synchronous) empties the queue and the result register and
// drops any running circle. A stalled result only fills the queue; full
// rises once both entries wait.
module circle_pixel_rasterizer #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 320
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          func,
  input  logic [cpr_pkg::CC_W-1:0]      centre_col,
  input  logic [cpr_pkg::CR_W-1:0]      centre_row,
  input  logic [cpr_pkg::RAD_W-1:0]     radius,
  input  logic [cpr_pkg::NIB_W-1:0]     alpha_nibble,
  input  logic [cpr_pkg::NIB_W-1:0]     red_nibble,
  input  logic [cpr_pkg::NIB_W-1:0]     green_nibble,
  input  logic [cpr_pkg::NIB_W-1:0]     blue_nibble,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    status,
  output logic [cpr_pkg::IDX_W-1:0]     pixel_index,
  output logic [cpr_pkg::COLOUR_W-1:0]  pixel_colour,
  output logic                          last_pixel
);
  import cpr_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic q_empty;
  logic q_take;
  cmd_t q_head;

  // a transaction is taken whenever the queue has room
  assign accept = push && !full;

  // classify and step the circle state
  cpr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .func         (func),
    .centre_col   (centre_col),
    .centre_row   (centre_row),
    .radius       (radius),
    .alpha_nibble (alpha_nibble),
    .red_nibble   (red_nibble),
    .green_nibble (green_nibble),
    .blue_nibble  (blue_nibble),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd)
  );

  // decouples the front from a stalled result port
  cpr_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_valid),
    .wr_data (cmd),
    .rd      (q_take),
    .rd_data (q_head),
    .full    (full),
    .empty   (q_empty)
  );

  // index arithmetic and result register
  cpr_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (!q_empty),
    .cmd          (q_head),
    .cmd_take     (q_take),
    .pop          (pop),
    .empty        (empty),
    .status       (status),
    .pixel_index  (pixel_index),
    .pixel_colour (pixel_colour),
    .last_pixel   (last_pixel)
  );

endmodule
